// ===== rtl/core/cjd_pkg.sv =====
// shared types, constants and the month term table for the julian day converter
package cjd_pkg;

	localparam int unsigned REG_W  = 35;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned ADDR_W = 4;

	localparam logic signed [REG_W-1:0] LAST_JULIAN_RESET    = 35'sd17520902;
	localparam logic signed [REG_W-1:0] FIRST_GREGORIAN_RESET = 35'sd17520914;

	localparam logic signed [20:0] YEAR_MIN = -21'sd1000000;
	localparam logic signed [20:0] YEAR_MAX = 21'sd1000000;

	// register byte addresses, one 64-bit slot per register
	localparam logic [ADDR_W-1:0] ADDR_LAST_JULIAN    = 4'h0;
	localparam logic [ADDR_W-1:0] ADDR_FIRST_GREGORIAN = 4'h8;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_YEAR   = 3'd1,
		ST_DAY    = 3'd2,
		ST_HOUR   = 3'd3,
		ST_MINUTE = 3'd4,
		ST_SECOND = 3'd5,
		ST_MONTH  = 3'd6,
		ST_GAP    = 3'd7
	} status_t;

	typedef struct packed {
		logic signed [20:0] cal_year;
		logic [3:0]         cal_month;
		logic [4:0]         cal_day;
		logic [4:0]         cal_hour;
		logic [5:0]         cal_minute;
		logic [5:0]         cal_second;
	} date_t;

	typedef struct packed {
		logic signed [29:0] day_number;
		logic [16:0]        seconds_of_day;
		status_t            status;
	} result_t;

	// floor(30.6001*(m+1)) for the shifted month m = 3..14
	function automatic logic [8:0] month_term(input logic [3:0] m);
		logic [8:0] t;
		case (m)
			4'd3:    t = 9'd122;
			4'd4:    t = 9'd153;
			4'd5:    t = 9'd183;
			4'd6:    t = 9'd214;
			4'd7:    t = 9'd244;
			4'd8:    t = 9'd275;
			4'd9:    t = 9'd306;
			4'd10:   t = 9'd336;
			4'd11:   t = 9'd367;
			4'd12:   t = 9'd397;
			4'd13:   t = 9'd428;
			4'd14:   t = 9'd459;
			default: t = 9'd0;
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/core/cjd_calc.sv =====
// combinational date check and julian day arithmetic
module cjd_calc (
	input  cjd_pkg::date_t                          date,
	input  logic signed [cjd_pkg::REG_W-1:0]        last_julian_date,
	input  logic signed [cjd_pkg::REG_W-1:0]        first_gregorian_date,
	output cjd_pkg::result_t                        result
);

	logic signed [20:0] yr;
	logic [10:0]        md;
	logic signed [34:0] req;
	logic               early;
	logic [3:0]         mo_adj;
	logic signed [21:0] ya;
	logic [20:0]        ya_mag;
	logic [42:0]        prod;
	logic [14:0]        q100;
	logic [12:0]        q400;
	logic [18:0]        q4;
	logic signed [21:0] mag_g;
	logic signed [21:0] b_greg;
	logic signed [22:0] v;
	logic signed [22:0] v_adj;
	logic signed [22:0] b_jul;
	logic signed [22:0] b_sel;
	logic signed [31:0] dn;
	logic [16:0]        sod;
	cjd_pkg::status_t   st;

	assign yr  = date.cal_year;
	assign md  = 11'(date.cal_month) * 11'd100 + 11'(date.cal_day);
	assign req = 35'(yr) * 35'sd10000 + $signed({24'd0, md});

	// jan and feb count as months 13 and 14 of the year before
	assign early  = (date.cal_month <= 4'd2);
	assign mo_adj = early ? date.cal_month + 4'd12 : date.cal_month;
	assign ya     = early ? 22'(yr) - 22'sd1 : 22'(yr);
	assign ya_mag = ya[21] ? 21'(-ya) : 21'(ya);

	// truncating divide of the magnitude by 100 through a reciprocal
	assign prod  = 43'(ya_mag) * 43'd2684355;
	assign q100  = prod[42:28];
	assign q400  = q100[14:2];
	assign q4    = ya_mag[20:2];
	assign mag_g = $signed({3'd0, q4}) + $signed({9'd0, q400}) - $signed({7'd0, q100});
	assign b_greg = ya[21] ? -mag_g : mag_g;

	// julian term, (y+4716)/4 rounded toward zero less 1181
	assign v     = 23'(ya) + 23'sd4716;
	assign v_adj = v[22] ? v + 23'sd3 : v;
	assign b_jul = (v_adj >>> 2) - 23'sd1181;

	always_comb begin
		b_sel = 23'sd0;
		if (yr < cjd_pkg::YEAR_MIN || yr > cjd_pkg::YEAR_MAX) begin
			st = cjd_pkg::ST_YEAR;
		end else if (date.cal_day == 5'd0) begin
			st = cjd_pkg::ST_DAY;
		end else if (date.cal_hour > 5'd23) begin
			st = cjd_pkg::ST_HOUR;
		end else if (date.cal_minute > 6'd59) begin
			st = cjd_pkg::ST_MINUTE;
		end else if (date.cal_second > 6'd59) begin
			st = cjd_pkg::ST_SECOND;
		end else if (date.cal_month == 4'd0 || date.cal_month > 4'd12) begin
			st = cjd_pkg::ST_MONTH;
		end else if (req <= last_julian_date) begin
			st    = cjd_pkg::ST_OK;
			b_sel = b_jul;
		end else if (req >= first_gregorian_date) begin
			st    = cjd_pkg::ST_OK;
			b_sel = 23'(b_greg);
		end else begin
			st = cjd_pkg::ST_GAP;
		end
	end

	assign dn = 32'(ya) * 32'sd365 + 32'sd1720997 + 32'(b_sel)
		+ $signed({23'd0, cjd_pkg::month_term(mo_adj)}) + $signed({27'd0, date.cal_day});

	assign sod = 17'(date.cal_hour) * 17'd3600 + 17'(date.cal_minute) * 17'd60
		+ 17'(date.cal_second);

	always_comb begin
		result.status = st;
		if (st == cjd_pkg::ST_OK) begin
			result.day_number     = dn[29:0];
			result.seconds_of_day = sod;
		end else begin
			result.day_number     = 30'sd0;
			result.seconds_of_day = 17'd0;
		end
	end

endmodule

// ===== rtl/core/calendar_date_to_julian_day.sv =====
// top level: register port, request register and result register around the converter
// a request passes the input register and then the result register, which shows its result with done high
// throughput: one request per cycle, busy stays low; the path is one input register,
// the check and day arithmetic (one constant reciprocal multiply), then the result register
// results cannot be stalled: each is marked by done for exactly one cycle
// reset clears both valid flags and loads the calendar switch registers with their defaults
module calendar_date_to_julian_day (
	input  logic                                clk,
	input  logic                                arst_n,
	// register port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cjd_pkg::ADDR_W-1:0]          paddr,
	input  logic [cjd_pkg::DATA_W-1:0]          pwdata,
	output logic [cjd_pkg::DATA_W-1:0]          prdata,
	output logic                                pready,
	// request
	input  logic                                start,
	output logic                                busy,
	input  logic signed [20:0]                  cal_year,
	input  logic [3:0]                          cal_month,
	input  logic [4:0]                          cal_day,
	input  logic [4:0]                          cal_hour,
	input  logic [5:0]                          cal_minute,
	input  logic [5:0]                          cal_second,
	// result
	output logic                                done,
	output logic signed [29:0]                  day_number,
	output logic [16:0]                         seconds_of_day,
	output logic [2:0]                          status
);

	logic signed [cjd_pkg::REG_W-1:0] last_julian_q;
	logic signed [cjd_pkg::REG_W-1:0] first_gregorian_q;
	logic                             cfg_wr;

	logic                             valid_s1;
	cjd_pkg::date_t                   date_s1;
	cjd_pkg::result_t                 calc_res;
	logic                             valid_s2;
	cjd_pkg::result_t                 res_s2;

	// every request is taken; the pipe never holds one off
	assign busy   = 1'b0;
	assign pready = 1'b1;

	// register writes complete in the access phase; bit 3 of the address picks the register
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_julian_q     <= cjd_pkg::LAST_JULIAN_RESET;
			first_gregorian_q <= cjd_pkg::FIRST_GREGORIAN_RESET;
		end else if (cfg_wr) begin
			if (paddr[3] == cjd_pkg::ADDR_FIRST_GREGORIAN[3]) begin
				first_gregorian_q <= $signed(pwdata[cjd_pkg::REG_W-1:0]);
			end else begin
				last_julian_q <= $signed(pwdata[cjd_pkg::REG_W-1:0]);
			end
		end
	end

	// read data comes back sign extended to the bus width
	always_comb begin
		if (paddr[3] == cjd_pkg::ADDR_FIRST_GREGORIAN[3]) begin
			prdata = cjd_pkg::DATA_W'(first_gregorian_q);
		end else begin
			prdata = cjd_pkg::DATA_W'(last_julian_q);
		end
	end

	// stage 1: capture the request fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			date_s1.cal_year   <= cal_year;
			date_s1.cal_month  <= cal_month;
			date_s1.cal_day    <= cal_day;
			date_s1.cal_hour   <= cal_hour;
			date_s1.cal_minute <= cal_minute;
			date_s1.cal_second <= cal_second;
		end
	end

	// checks, calendar choice and day arithmetic
	cjd_calc u_calc (
		.date                 (date_s1),
		.last_julian_date     (last_julian_q),
		.first_gregorian_date (first_gregorian_q),
		.result               (calc_res)
	);

	// stage 2: result register, shown for one cycle with done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= calc_res;
		end
	end

	assign done           = valid_s2;
	assign day_number     = res_s2.day_number;
	assign seconds_of_day = res_s2.seconds_of_day;
	assign status         = res_s2.status;

endmodule
